>>> rtl/core/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types, constants and the method lookup for the HTTP/TLS flow
// classifier.
// ----------------------------------------------------------------------------
package hfc_pkg;

   // default path capacity in bytes
   localparam int PATH_BYTES_DEF = 128;

   // character and header codes
   localparam logic [7:0]  CHAR_SPACE    = 8'h20;
   localparam logic [7:0]  CHAR_SLASH    = 8'h2F;
   localparam logic [7:0]  CHAR_NUL      = 8'h00;
   localparam logic [31:0] HTTP_WORD     = 32'h4854_5450;
   localparam logic [7:0]  TLS_APPDATA   = 8'h17;
   localparam logic [7:0]  TLS_MAJOR     = 8'h03;
   localparam logic [7:0]  TLS_MINOR_MAX = 8'h03;

   // verdict codes
   localparam logic [1:0] VERDICT_NONE = 2'd0;
   localparam logic [1:0] VERDICT_HTTP = 2'd1;
   localparam logic [1:0] VERDICT_TLS  = 2'd2;

   // method codes
   localparam logic [3:0] METHOD_GET     = 4'd0;
   localparam logic [3:0] METHOD_POST    = 4'd1;
   localparam logic [3:0] METHOD_PUT     = 4'd2;
   localparam logic [3:0] METHOD_DELETE  = 4'd3;
   localparam logic [3:0] METHOD_HEAD    = 4'd4;
   localparam logic [3:0] METHOD_OPTIONS = 4'd5;
   localparam logic [3:0] METHOD_TRACE   = 4'd6;
   localparam logic [3:0] METHOD_CONNECT = 4'd7;
   localparam logic [3:0] METHOD_PATCH   = 4'd8;
   localparam logic [3:0] METHOD_NONE    = 4'd9;
   localparam int         METHOD_COUNT   = 9;

   // method names, first character in the low byte, zero padded
   localparam logic [63:0] METHOD_NAME [METHOD_COUNT] = '{
      64'h0000_0000_0054_4547,   // GET
      64'h0000_0000_5453_4F50,   // POST
      64'h0000_0000_0054_5550,   // PUT
      64'h0000_4554_454C_4544,   // DELETE
      64'h0000_0000_4441_4548,   // HEAD
      64'h0053_4E4F_4954_504F,   // OPTIONS
      64'h0000_0045_4341_5254,   // TRACE
      64'h0054_4345_4E4E_4F43,   // CONNECT
      64'h0000_0048_4354_4150    // PATCH
   };
   localparam logic [3:0] METHOD_LEN [METHOD_COUNT] = '{
      4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd7, 4'd5
   };

   // input item
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        first_byte;
      logic        last_byte;
      logic        is_tcp;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
   } req_type;

   // result item
   typedef struct packed {
      logic [1:0]  verdict;
      logic [3:0]  method_index;
      logic [31:0] requester_ip;
      logic [31:0] server_ip;
      logic [15:0] server_port;
      logic [63:0] path_chunk;
      logic [3:0]  chunk_bytes;
      logic        last_result;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic consume;    // apply the accepted byte
      logic evaluate;   // settle the verdict
      logic read;       // fetch the current path word
      logic advance;    // step to the next chunk
   } hfc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_chunk;
   } hfc_sts_type;

   // match a token against the method list, ignoring case
   function automatic logic [3:0] method_match(input logic [63:0] text,
                                               input logic [3:0]  len);
      logic [63:0] up;
      logic [3:0]  idx;
      up  = text;
      idx = METHOD_NONE;
      for (int i = 0; i < 8; i++) begin
         if (text[8*i +: 8] >= 8'h61 && text[8*i +: 8] <= 8'h7A) begin
            up[8*i +: 8] = text[8*i +: 8] - 8'h20;
         end
      end
      for (int m = METHOD_COUNT - 1; m >= 0; m--) begin
         if (len == METHOD_LEN[m] && up == METHOD_NAME[m]) begin
            idx = 4'(m);
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/core/hfc_ram.sv
// ----------------------------------------------------------------------------
// hfc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module hfc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hfc_ctrl.sv
// ----------------------------------------------------------------------------
// hfc_ctrl
// Sequencer: packet framing, verdict evaluation and chunk emission.
// ----------------------------------------------------------------------------
module hfc_ctrl
   import hfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_first,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hfc_cmd_type cmd,
   input  hfc_sts_type sts
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_OPEN = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_READ = 5'b01000,
      ST_SHOW = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      req_fire;

   assign req_ready = (state_ff == ST_IDLE) || (state_ff == ST_OPEN);
   assign rsp_valid = (state_ff == ST_SHOW);
   assign req_fire  = req_valid && req_ready;

   // commands to the datapath
   always_comb begin
      cmd.consume  = req_fire && (req_first || state_ff == ST_OPEN);
      cmd.evaluate = (state_ff == ST_EVAL);
      cmd.read     = (state_ff == ST_READ);
      cmd.advance  = (state_ff == ST_SHOW) && rsp_ready && !sts.last_chunk;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_first) begin
               state_in = req_last ? ST_EVAL : ST_OPEN;
            end
         end
         ST_OPEN: begin
            if (req_fire && req_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               state_in = sts.last_chunk ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/hfc_dp.sv
// ----------------------------------------------------------------------------
// hfc_dp
// Datapath: byte tokeniser, HTTP and TLS detection, path buffer and result
// formatting.
// ----------------------------------------------------------------------------
module hfc_dp
   import hfc_pkg::*;
#(
   parameter int PATH_BYTES = PATH_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   output rsp_type     rsp_data,
   input  hfc_cmd_type cmd,
   output hfc_sts_type sts
);

   localparam int WORDS = (PATH_BYTES + 7) / 8;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LW    = $clog2(PATH_BYTES + 1);
   localparam logic [2:0] POS_SAT = 3'd4;

   typedef enum logic [4:0] {
      PH_LEAD   = 5'b00001,
      PH_METHOD = 5'b00010,
      PH_GAP    = 5'b00100,
      PH_PATH   = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        ended_ff, ended_in;
   logic [2:0]  pos_ff, pos_in;
   logic [23:0] recent_ff, recent_in;
   logic        seen_ff, seen_in;
   logic        starts_ff, starts_in;
   logic [63:0] mtext_ff, mtext_in;
   logic [3:0]  mlen_ff, mlen_in;
   logic [LW-1:0] plen_ff, plen_in;
   logic [63:0] acc_ff, acc_in;
   logic [23:0] tls_ff, tls_in;
   logic        tcp_ff, tcp_in;
   logic [31:0] sip_ff, sip_in;
   logic [31:0] dip_ff, dip_in;
   logic [15:0] dport_ff, dport_in;
   logic [1:0]  verdict_ff, verdict_in;
   logic [3:0]  midx_ff, midx_in;
   logic        slash_ff, slash_in;
   logic [LW-1:0] remain_ff, remain_in;
   logic [AW-1:0] chunk_ff, chunk_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [63:0]   ram_wdata;
   logic [63:0]   ram_rdata;
   logic          full_word;

   // full path words
   hfc_ram #(
      .WIDTH (64),
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_path_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.read),
      .rd_addr (chunk_ff),
      .rd_data (ram_rdata)
   );

   // tokenise the byte stream, then settle the verdict and walk the chunks
   always_comb begin
      logic [31:0] word;
      logic        at_three;
      logic        is_space;
      logic        m_app;
      logic        p_app;
      logic [3:0]  mm;
      logic        tls_ok;

      phase_in   = phase_ff;
      ended_in   = ended_ff;
      pos_in     = pos_ff;
      recent_in  = recent_ff;
      seen_in    = seen_ff;
      starts_in  = starts_ff;
      mtext_in   = mtext_ff;
      mlen_in    = mlen_ff;
      plen_in    = plen_ff;
      acc_in     = acc_ff;
      tls_in     = tls_ff;
      tcp_in     = tcp_ff;
      sip_in     = sip_ff;
      dip_in     = dip_ff;
      dport_in   = dport_ff;
      verdict_in = verdict_ff;
      midx_in    = midx_ff;
      slash_in   = slash_ff;
      remain_in  = remain_ff;
      chunk_in   = chunk_ff;
      ram_we     = 1'b0;
      ram_waddr  = AW'(plen_ff >> 3);
      ram_wdata  = acc_ff;
      word       = '0;
      at_three   = 1'b0;
      is_space   = 1'b0;
      m_app      = 1'b0;
      p_app      = 1'b0;
      mm         = METHOD_NONE;
      tls_ok     = 1'b0;

      if (cmd.consume) begin
         // open a new packet: clear the parse state, latch the addresses
         if (req_data.first_byte) begin
            phase_in  = PH_LEAD;
            ended_in  = 1'b0;
            pos_in    = '0;
            recent_in = '0;
            seen_in   = 1'b0;
            starts_in = 1'b0;
            mtext_in  = '0;
            mlen_in   = '0;
            plen_in   = '0;
            acc_in    = '0;
            tls_in    = '0;
            tcp_in    = req_data.is_tcp;
            sip_in    = req_data.source_ip;
            dip_in    = req_data.dest_ip;
            dport_in  = req_data.dest_port;
         end

         // raw header bytes and saturating position
         if (pos_in < 3'd3) begin
            tls_in[8*pos_in[1:0] +: 8] = req_data.payload_byte;
         end
         at_three = (pos_in == 3'd3);
         if (pos_in != POS_SAT) begin
            pos_in = pos_in + 3'd1;
         end

         if (!ended_in) begin
            if (req_data.payload_byte == CHAR_NUL) begin
               ended_in = 1'b1;
            end else begin
               word = {recent_in, req_data.payload_byte};
               if (word == HTTP_WORD) begin
                  seen_in = 1'b1;
                  if (at_three) begin
                     starts_in = 1'b1;
                  end
               end
               recent_in = word[23:0];
               is_space  = (req_data.payload_byte == CHAR_SPACE);

               unique case (phase_in)
                  PH_LEAD: begin
                     if (!is_space) begin
                        phase_in = PH_METHOD;
                        m_app    = 1'b1;
                     end
                  end
                  PH_METHOD: begin
                     if (is_space) begin
                        phase_in = PH_GAP;
                     end else begin
                        m_app = 1'b1;
                     end
                  end
                  PH_GAP: begin
                     if (!is_space) begin
                        phase_in = PH_PATH;
                        p_app    = 1'b1;
                     end
                  end
                  PH_PATH: begin
                     if (is_space) begin
                        phase_in = PH_DONE;
                     end else begin
                        p_app = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase

               // append to the method token, drop beyond eight characters
               if (m_app && mlen_in < 4'd8) begin
                  mtext_in[8*mlen_in[2:0] +: 8] = req_data.payload_byte;
                  mlen_in = mlen_in + 4'd1;
               end

               // append to the path, flush each complete word to memory
               if (p_app && plen_in < LW'(PATH_BYTES)) begin
                  acc_in[8*plen_in[2:0] +: 8] = req_data.payload_byte;
                  if (plen_in[2:0] == 3'd7) begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(plen_in >> 3);
                     ram_wdata = acc_in;
                     acc_in    = '0;
                  end
                  plen_in = plen_in + LW'(1);
               end
            end
         end
      end

      // settle the verdict and the number of path bytes to emit
      if (cmd.evaluate) begin
         mm     = method_match(mtext_ff, mlen_ff);
         tls_ok = (pos_ff >= 3'd3) && (tls_ff[7:0] == TLS_APPDATA) &&
                  (tls_ff[15:8] == TLS_MAJOR) && (tls_ff[23:16] <= TLS_MINOR_MAX);
         verdict_in = VERDICT_NONE;
         midx_in    = METHOD_GET;
         slash_in   = 1'b0;
         remain_in  = '0;
         chunk_in   = '0;
         if (tcp_ff) begin
            if (!starts_ff && seen_ff) begin
               if (mm != METHOD_NONE) begin
                  verdict_in = VERDICT_HTTP;
                  midx_in    = mm;
                  if (plen_ff == '0) begin
                     slash_in  = 1'b1;
                     remain_in = LW'(1);
                  end else begin
                     remain_in = plen_ff;
                  end
               end
            end else if (tls_ok) begin
               verdict_in = VERDICT_TLS;
               slash_in   = 1'b1;
               remain_in  = LW'(1);
            end
         end
      end

      // step past a delivered chunk
      if (cmd.advance) begin
         remain_in = remain_ff - LW'(8);
         chunk_in  = chunk_ff + AW'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEAD;
         ended_ff   <= 1'b0;
         verdict_ff <= VERDICT_NONE;
         remain_ff  <= '0;
         chunk_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         ended_ff   <= ended_in;
         verdict_ff <= verdict_in;
         remain_ff  <= remain_in;
         chunk_ff   <= chunk_in;
      end
   end

   // parse and packet registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      recent_ff <= recent_in;
      seen_ff   <= seen_in;
      starts_ff <= starts_in;
      mtext_ff  <= mtext_in;
      mlen_ff   <= mlen_in;
      plen_ff   <= plen_in;
      acc_ff    <= acc_in;
      tls_ff    <= tls_in;
      tcp_ff    <= tcp_in;
      sip_ff    <= sip_in;
      dip_ff    <= dip_in;
      dport_ff  <= dport_in;
      midx_ff   <= midx_in;
      slash_ff  <= slash_in;
   end

   // format the current chunk
   assign full_word      = (remain_ff >= LW'(8));
   assign sts.last_chunk = (remain_ff <= LW'(8));

   always_comb begin
      rsp_data.verdict      = verdict_ff;
      rsp_data.method_index = midx_ff;
      rsp_data.requester_ip = sip_ff;
      rsp_data.server_ip    = dip_ff;
      rsp_data.server_port  = dport_ff;
      rsp_data.last_result  = sts.last_chunk;
      rsp_data.chunk_bytes  = full_word ? 4'd8 : 4'(remain_ff);
      if (slash_ff) begin
         rsp_data.path_chunk = {56'd0, CHAR_SLASH};
      end else if (full_word) begin
         rsp_data.path_chunk = ram_rdata;
      end else if (verdict_ff == VERDICT_HTTP) begin
         rsp_data.path_chunk = acc_ff;
      end else begin
         rsp_data.path_chunk = '0;
      end
   end

endmodule

>>> rtl/core/http_tls_flow_classifier.sv
// Takes one payload byte per cycle while a packet is open.
// After the last byte transfer the input is held off; the verdict is settled,
// then each path chunk is fetched and presented in turn (memory read, then show),
// one path word per chunk from a single read port.
// Reset is synchronous and returns the sequencer to idle; path memory is
// not initialised.
// ----------------------------------------------------------------------------
// http_tls_flow_classifier
// Classifies a TCP payload as an HTTP request or TLS application data and
// reports the request path in 8-byte chunks.
// ----------------------------------------------------------------------------
module http_tls_flow_classifier
   import hfc_pkg::*;
#(
   parameter int PATH_BYTES = PATH_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   hfc_cmd_type cmd;
   hfc_sts_type sts;

   // sequencer
   hfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_first (req_data.first_byte),
      .req_last  (req_data.last_byte),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // parse and result datapath
   hfc_dp #(
      .PATH_BYTES (PATH_BYTES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

   // input and output never open together
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input accepted while a result is pending");

   // a chunk never claims more than eight bytes
   a_chunk_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.chunk_bytes <= 4'd8)
      else $error("chunk byte count out of range");

   // an unclassified packet gives one empty result
   a_none_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.verdict == VERDICT_NONE) |->
         (rsp_data.chunk_bytes == 4'd0 && rsp_data.last_result &&
          rsp_data.path_chunk == 64'd0))
      else $error("unclassified result carries path data");

   // the final transfer reopens the input
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_result) |=> req_ready)
      else $error("input not reopened after final result");

endmodule

>>> test/http_tls_flow_classifier_test.sv
// ----------------------------------------------------------------------------
// http_tls_flow_classifier_test
// Drives framed payload bytes into the flow classifier and checks every path
// chunk against an in-bench classifier, with random stalls on both channels.
// ----------------------------------------------------------------------------
module http_tls_flow_classifier_test;
   import hfc_pkg::*;

   localparam int PATH_MAX      = PATH_BYTES_DEF;
   localparam int SETTLE_CYCLES = 48;
   localparam int REPORT_LIMIT  = 40;
   localparam int REQ_BITS      = $bits(req_type);

   typedef enum logic [2:0] {
      PH_IDLE, PH_LEAD, PH_METHOD, PH_GAP, PH_PATH, PH_DONE
   } parse_phase_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   http_tls_flow_classifier u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // classifier state mirrored in the bench
   parse_phase_type phase_q = PH_IDLE;
   logic [23:0]     tail_q = '0;
   bit              http_found = 1'b0;
   bit              http_at_start = 1'b0;
   logic [15:0]     count_q = '0;
   logic [63:0]     token_q = '0;      // first character ends in the top used byte
   int              token_len = 0;
   logic [7:0]      path_q [PATH_MAX];
   int              path_len = 0;
   logic [23:0]     tls_q = '0;
   bit              text_ended = 1'b0;
   bit              tcp_q = 1'b0;
   logic [31:0]     client_q = '0;
   logic [31:0]     server_q = '0;
   logic [15:0]     port_q = '0;

   rsp_type         pending_chunks [$];
   logic [7:0]      pkt_bytes [$];
   int              items_sent = 0;
   int              chunks_predicted = 0;
   int              mismatch_count = 0;
   bit              gaps_enabled = 1'b0;

   string verb_spelling [9] = '{"GET", "POST", "PUT", "DELETE", "HEAD", "OPTIONS",
                                "TRACE", "CONNECT", "PATCH"};

   // Advance the bench classifier by one accepted byte; queue chunks on last byte
   task automatic classify_byte(input req_type r);
      logic [7:0]  b;
      logic [15:0] pos;
      logic [31:0] window;
      logic [63:0] upper;
      logic [1:0]  verdict;
      logic [3:0]  method;
      bit          known;
      int          plen;
      int          done;
      int          cnt;
      rsp_type     res;
      b = r.payload_byte;
      if (r.first_byte) begin
         phase_q       = PH_LEAD;
         tail_q        = '0;
         http_found    = 1'b0;
         http_at_start = 1'b0;
         count_q       = '0;
         token_q       = '0;
         token_len     = 0;
         path_len      = 0;
         tls_q         = '0;
         text_ended    = 1'b0;
         tcp_q         = r.is_tcp;
         client_q      = r.source_ip;
         server_q      = r.dest_ip;
         port_q        = r.dest_port;
      end else if (phase_q == PH_IDLE) begin
         return;
      end

      // raw bytes fill the record header even after the text has ended
      pos = count_q;
      if (pos < 16'd3) tls_q = tls_q | (24'(b) << (8 * pos));
      if (count_q != 16'hFFFF) count_q = count_q + 16'd1;

      if (!text_ended) begin
         if (b == CHAR_NUL) begin
            text_ended = 1'b1;
         end else begin
            window = {tail_q, b};
            if (window == HTTP_WORD) begin
               http_found = 1'b1;
               if (pos == 16'd3) http_at_start = 1'b1;
            end
            tail_q = window[23:0];
            case (phase_q)
               PH_LEAD, PH_METHOD: begin
                  if (b == CHAR_SPACE) begin
                     if (phase_q == PH_METHOD) phase_q = PH_GAP;
                  end else begin
                     phase_q = PH_METHOD;
                     if (token_len < 8) begin
                        token_q   = {token_q[55:0], b};
                        token_len = token_len + 1;
                     end
                  end
               end
               PH_GAP, PH_PATH: begin
                  if (b == CHAR_SPACE) begin
                     if (phase_q == PH_PATH) phase_q = PH_DONE;
                  end else begin
                     phase_q = PH_PATH;
                     if (path_len < PATH_MAX) begin
                        path_q[path_len] = b;
                        path_len = path_len + 1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      if (!r.last_byte) return;

      // settle the verdict
      verdict = VERDICT_NONE;
      method  = METHOD_GET;      // zero unless the request is HTTP
      plen    = 0;
      if (tcp_q) begin
         if (!http_at_start && http_found) begin
            upper = token_q;
            for (int i = 0; i < 8; i++) begin
               if (upper[8*i +: 8] >= 8'h61 && upper[8*i +: 8] <= 8'h7A) begin
                  upper[8*i +: 8] = upper[8*i +: 8] - 8'h20;
               end
            end
            known = 1'b1;
            case (upper)
               {40'h0, "GET"}:     method = METHOD_GET;
               {32'h0, "POST"}:    method = METHOD_POST;
               {40'h0, "PUT"}:     method = METHOD_PUT;
               {16'h0, "DELETE"}:  method = METHOD_DELETE;
               {32'h0, "HEAD"}:    method = METHOD_HEAD;
               {8'h0, "OPTIONS"}:  method = METHOD_OPTIONS;
               {24'h0, "TRACE"}:   method = METHOD_TRACE;
               {8'h0, "CONNECT"}:  method = METHOD_CONNECT;
               {24'h0, "PATCH"}:   method = METHOD_PATCH;
               default:            known  = 1'b0;
            endcase
            if (known) begin
               verdict = VERDICT_HTTP;
               if (path_len == 0) begin
                  path_q[0] = CHAR_SLASH;
                  path_len  = 1;
               end
               plen = path_len;
            end
         end else if (count_q >= 16'd3 && tls_q[7:0] == TLS_APPDATA &&
                      tls_q[15:8] == TLS_MAJOR && tls_q[23:16] <= TLS_MINOR_MAX) begin
            verdict   = VERDICT_TLS;
            path_q[0] = CHAR_SLASH;
            path_len  = 1;
            plen      = 1;
         end
      end

      // split the path into chunks of eight, always at least one
      done = 0;
      do begin
         cnt                = (plen - done > 8) ? 8 : plen - done;
         res                = '0;
         res.verdict        = verdict;
         res.method_index   = method;
         res.requester_ip   = client_q;
         res.server_ip      = server_q;
         res.server_port    = port_q;
         for (int i = 0; i < cnt; i++) res.path_chunk[8*i +: 8] = path_q[done + i];
         done               = done + cnt;
         res.chunk_bytes    = 4'(cnt);
         res.last_result    = (done >= plen);
         pending_chunks.push_back(res);
         chunks_predicted++;
      end while (done < plen);
      phase_q = PH_IDLE;
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
   endtask

   // Compare each result transfer with the oldest pending chunk
   rsp_type oldest_chunk;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chunks.size() == 0) begin
            report_mismatch("result transfer with nothing pending");
         end else begin
            oldest_chunk = pending_chunks.pop_front();
            check_field("verdict", 64'(rsp_data.verdict), 64'(oldest_chunk.verdict));
            check_field("method_index", 64'(rsp_data.method_index),
                        64'(oldest_chunk.method_index));
            check_field("requester_ip", 64'(rsp_data.requester_ip),
                        64'(oldest_chunk.requester_ip));
            check_field("server_ip", 64'(rsp_data.server_ip), 64'(oldest_chunk.server_ip));
            check_field("server_port", 64'(rsp_data.server_port),
                        64'(oldest_chunk.server_port));
            check_field("path_chunk", rsp_data.path_chunk, oldest_chunk.path_chunk);
            check_field("chunk_bytes", 64'(rsp_data.chunk_bytes),
                        64'(oldest_chunk.chunk_bytes));
            check_field("last_result", 64'(rsp_data.last_result),
                        64'(oldest_chunk.last_result));
         end
      end
   end

   // Stall the result channel in random bursts while gaps are enabled
   initial begin
      forever begin
         @(negedge clock);
         if (gaps_enabled && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Send one input transfer, with an optional idle burst in front
   task automatic send_item(input req_type r);
      int gap;
      if (gaps_enabled && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      classify_byte(r);
   endtask

   // Send the collected bytes as one packet; metadata counts on the first byte only
   task automatic send_packet(input bit tcp, input bit close, input logic [31:0] src,
                              input logic [31:0] dst, input logic [15:0] port);
      req_type r;
      foreach (pkt_bytes[i]) begin
         r.payload_byte = pkt_bytes[i];
         r.first_byte   = (i == 0);
         r.last_byte    = close && (i == pkt_bytes.size() - 1);
         if (i == 0) begin
            r.is_tcp    = tcp;
            r.source_ip = src;
            r.dest_ip   = dst;
            r.dest_port = port;
         end else begin
            r.is_tcp    = 1'($urandom);
            r.source_ip = $urandom;
            r.dest_ip   = $urandom;
            r.dest_port = 16'($urandom);
         end
         send_item(r);
         items_sent++;
      end
      pkt_bytes.delete();
   endtask

   task automatic send_flow(input bit tcp);
      send_packet(tcp, 1'b1, $urandom, $urandom, 16'($urandom));
   endtask

   // Bytes without a first-byte mark, ignored while no packet is open
   task automatic send_stray(input int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         r              = req_type'(REQ_BITS'({$urandom, $urandom, $urandom}));
         r.first_byte   = 1'b0;
         r.last_byte    = i[0];
         send_item(r);
      end
   endtask

   task automatic add_text(input string s);
      foreach (s[i]) pkt_bytes.push_back(s[i]);
   endtask

   // Append a request line: method, path of printable characters, protocol
   task automatic add_request(input int verb, input int lead, input int gap,
                              input int path_n, input bit mixed);
      string      spelling;
      logic [7:0] ch;
      spelling = verb_spelling[verb];
      repeat (lead) pkt_bytes.push_back(CHAR_SPACE);
      foreach (spelling[i]) begin
         ch = spelling[i];
         if (mixed && $urandom_range(0, 1) == 1) ch = ch + 8'h20;
         pkt_bytes.push_back(ch);
      end
      repeat (gap) pkt_bytes.push_back(CHAR_SPACE);
      repeat (path_n) pkt_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
      add_text(" HTTP");
   endtask

   // Drop valid and hold until every pending chunk has arrived
   task automatic await_results();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stray bytes, abandoned packets and single-byte packets
   task automatic test_framing();
      send_stray(4);
      add_request(0, 0, 1, 5, 1'b0);
      send_packet(1'b1, 1'b0, $urandom, $urandom, 16'($urandom));
      add_request(1, 0, 1, 3, 1'b0);
      send_flow(1'b1);
      add_text("A");
      send_flow(1'b1);
      send_stray(3);
   endtask

   // Every method, mixed case, extra spaces, chunk boundaries and address extremes
   task automatic test_methods();
      int path_lens [9] = '{1, 7, 8, 9, 16, 17, 2, 3, 5};
      for (int m = 0; m < 9; m++) begin
         add_request(m, (m == 4) ? 2 : 0, (m == 5) ? 3 : 1, path_lens[m], m[0]);
         if (m == 0) send_packet(1'b1, 1'b1, 32'h0, 32'h0, 16'h0);
         else if (m == 1) send_packet(1'b1, 1'b1, '1, '1, '1);
         else send_flow(1'b1);
      end
      add_text("get /HTTP");
      send_flow(1'b1);
   endtask

   // Record header: valid minors, bad version, bad type, short packets, not TCP
   task automatic test_tls_header();
      pkt_bytes = '{TLS_APPDATA, TLS_MAJOR, 8'h00};
      send_flow(1'b1);
      pkt_bytes = '{TLS_APPDATA, TLS_MAJOR, TLS_MINOR_MAX};
      repeat (5) pkt_bytes.push_back(8'($urandom));
      send_flow(1'b1);
      pkt_bytes = '{TLS_APPDATA, TLS_MAJOR, 8'h04, 8'h11};
      send_flow(1'b1);
      pkt_bytes = '{TLS_APPDATA, 8'h02, 8'h01, 8'h22};
      send_flow(1'b1);
      pkt_bytes = '{8'h16, TLS_MAJOR, 8'h01, 8'h33};
      send_flow(1'b1);
      pkt_bytes = '{TLS_APPDATA};
      send_flow(1'b1);
      pkt_bytes = '{TLS_APPDATA, TLS_MAJOR};
      send_flow(1'b1);
      pkt_bytes = '{TLS_APPDATA, TLS_MAJOR, 8'h02, 8'h44};
      send_flow(1'b0);
   endtask

   // Text that must not classify as a request
   task automatic test_rejects();
      add_text("HTTP 200");
      send_flow(1'b1);
      add_text("GET / HTTQ");
      send_flow(1'b1);
      add_text("FOO /x HTTP");
      send_flow(1'b1);
      add_text("GETGETGET /x HTTP");
      send_flow(1'b1);
      // unknown method suppresses the record header check
      pkt_bytes = '{TLS_APPDATA, TLS_MAJOR, 8'h01};
      add_text("HTTP");
      send_flow(1'b1);
      add_request(1, 0, 1, 4, 1'b0);
      send_flow(1'b0);
      add_text("HTT");
      send_flow(1'b1);
   endtask

   // A zero byte ends the text
   task automatic test_zero_byte();
      add_text("GET /ab");
      pkt_bytes.push_back(CHAR_NUL);
      add_text(" HTTP");
      send_flow(1'b1);
      add_text("PUT /ab HTTP");
      pkt_bytes.push_back(CHAR_NUL);
      add_text("zzz");
      send_flow(1'b1);
      pkt_bytes.push_back(CHAR_NUL);
      send_flow(1'b1);
   endtask

   // Truncation of a path longer than the store
   task automatic test_path_chunks();
      add_request($urandom_range(0, 8), 0, 1, PATH_MAX + 1, 1'b1);
      send_flow(1'b1);
   endtask

   // Mostly well-formed requests with random content, plus noise and breakage
   task automatic test_random_traffic(input int item_goal, input int result_goal);
      int item_mark;
      int result_mark;
      int kind;
      int n;
      item_mark   = items_sent;
      result_mark = chunks_predicted;
      while (items_sent - item_mark < item_goal ||
             chunks_predicted - result_mark < result_goal) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
            add_request($urandom_range(0, 8),
                        ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0,
                        $urandom_range(1, 3), n, $urandom_range(0, 1) == 1);
            repeat ($urandom_range(0, 6)) pkt_bytes.push_back(8'($urandom));
            // corrupt one byte
            if (kind == 5) pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = 8'($urandom);
         end else if (kind == 6) begin
            pkt_bytes = '{TLS_APPDATA, TLS_MAJOR, 8'($urandom_range(0, 5))};
            repeat ($urandom_range(0, 12)) pkt_bytes.push_back(8'($urandom));
         end else if (kind == 7) begin
            add_text("HTTP/1.1 200 OK");
         end else if (kind == 8) begin
            repeat ($urandom_range(1, 24)) pkt_bytes.push_back(8'($urandom));
         end else begin
            send_stray($urandom_range(1, 4));
         end
         if (kind != 9) begin
            send_packet($urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0,
                        $urandom, $urandom, 16'($urandom));
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      gaps_enabled = 1'b1;
      test_framing();
      test_methods();
      test_tls_header();
      test_rejects();
      test_zero_byte();
      test_path_chunks();
      test_random_traffic(30, 8);
      // hold the sender until the block has drained
      await_results();
      gaps_enabled = 1'b0;
      test_random_traffic(16, 4);
      await_results();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Timeout
   initial begin
      #4000000;
      $display("ERROR: timeout with %0d chunks pending", pending_chunks.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
